### src/irm_pkg.sv
// Shared types and constants for the image row mirror.
// Holds the item operation codes, the read request struct and the FIFO depth.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irm_pkg;

    // Channel byte width and the number of channels carried on the ports.
    localparam int CHAN_W     = 8;
    localparam int NUM_PORT_CH = 4;

    // Depth of the result FIFO in the back end.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = 2;
    localparam int FIFO_CW    = 3;

    // Register byte address of row_width.
    localparam logic [2:0] ADDR_ROW_WIDTH = 3'd0;

    // Operation codes of an input transaction.
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef logic [NUM_PORT_CH-1:0][CHAN_W-1:0] t_port_px;

    // Read request issued by the front end to the line store.
    typedef struct packed {
        logic en;
        logic last;
    } t_rd_req;

endpackage

`default_nettype wire

### src/irm_front.sv
// Front end of the image row mirror: accepts transactions, keeps the row counters
// and bank select, and issues line store writes and mirrored reads.
// Depends on irm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irm_front
    import irm_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int DW = CHAN_W * MAX_CHANNELS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [CW-1:0] i_width,
    input  wire logic          i_room,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire t_op           i_op,
    input  wire logic [DW-1:0] i_px,
    output logic               o_wr_en,
    output logic [IW:0]        o_wr_addr,
    output logic [DW-1:0]      o_wr_data,
    output t_rd_req            o_rd_req,
    output logic [IW:0]        o_rd_addr
);

    logic [CW-1:0] r_wr_col, n_wr_col;
    logic [CW-1:0] r_rd_col, n_rd_col;
    logic          r_wr_bank, n_wr_bank;
    logic          r_row_ready, n_row_ready;
    logic          accept;
    logic [CW-1:0] rd_pos;
    logic [CW-1:0] wr_pos;
    logic [CW-1:0] rd_next;
    logic [CW-1:0] wr_next;

    assign o_stall = !i_room;
    assign accept  = i_valid && i_room;

    // Counter update for one transaction: read part first, then the write part.
    always_comb begin
        n_wr_col    = r_wr_col;
        n_rd_col    = r_rd_col;
        n_wr_bank   = r_wr_bank;
        n_row_ready = r_row_ready;
        o_rd_req    = '{en: 1'b0, last: 1'b0};
        o_wr_en     = 1'b0;
        rd_pos      = i_width - CW'(1) - r_rd_col;
        rd_next     = r_rd_col + CW'(1);
        wr_pos      = (r_wr_col >= i_width) ? (i_width - CW'(1)) : r_wr_col;
        wr_next     = wr_pos + CW'(1);

        if (accept) begin
            // Mirrored read from the bank not being written.
            if (r_row_ready) begin
                if (r_rd_col >= i_width) begin
                    n_row_ready = 1'b0;
                end else begin
                    o_rd_req.en   = 1'b1;
                    o_rd_req.last = (rd_next == i_width);
                    n_rd_col      = rd_next;
                    if (rd_next >= i_width) begin
                        n_row_ready = 1'b0;
                    end
                end
            end
            // Pixel write; a completed row swaps the banks.
            if (i_op == OP_PIXEL) begin
                o_wr_en = 1'b1;
                if (wr_next >= i_width) begin
                    n_wr_bank   = !r_wr_bank;
                    n_wr_col    = '0;
                    n_rd_col    = '0;
                    n_row_ready = 1'b1;
                end else begin
                    n_wr_col = wr_next;
                end
            end
        end
    end

    assign o_wr_addr = {r_wr_bank, wr_pos[IW-1:0]};
    assign o_wr_data = i_px;
    assign o_rd_addr = {!r_wr_bank, rd_pos[IW-1:0]};

    // Counter and bank registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_col    <= '0;
            r_rd_col    <= '0;
            r_wr_bank   <= 1'b0;
            r_row_ready <= 1'b0;
        end else begin
            r_wr_col    <= n_wr_col;
            r_rd_col    <= n_rd_col;
            r_wr_bank   <= n_wr_bank;
            r_row_ready <= n_row_ready;
        end
    end

endmodule

`default_nettype wire

### src/irm_line_store.sv
// Ping-pong line store of the image row mirror: one write port and one read
// port with registered read data and a registered request tag.
// Depends on irm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irm_line_store
    import irm_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int DW = CHAN_W * MAX_CHANNELS,
    localparam int DEPTH = 2 << IW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [IW:0]   i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire t_rd_req       i_rd_req,
    input  wire logic [IW:0]   i_rd_addr,
    output t_rd_req            o_rd,
    output logic [DW-1:0]      o_rd_data
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rd_data;
    t_rd_req       r_rd;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_req.en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Request tag, registered on the same edge as the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '{en: 1'b0, last: 1'b0};
        end else begin
            r_rd <= i_rd_req;
        end
    end

    assign o_rd      = r_rd;
    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/irm_back.sv
// Back end of the image row mirror: a short FIFO of mirrored pixels that
// presents results on the output channel and reports room to the front end.
// Depends on irm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irm_back
    import irm_pkg::*;
#(
    parameter int MAX_CHANNELS = 4,
    localparam int DW = CHAN_W * MAX_CHANNELS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_rd_req       i_rd,
    input  wire logic [DW-1:0] i_rd_data,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [DW-1:0]      o_px,
    output logic               o_last
);

    logic [DW:0]         r_fifo [0:FIFO_DEPTH-1];
    logic [FIFO_PW-1:0]  r_wr_ptr;
    logic [FIFO_PW-1:0]  r_rd_ptr;
    logic [FIFO_CW-1:0]  r_count;
    logic [FIFO_CW-1:0]  pending;
    logic                push;
    logic                pop;

    assign push    = i_rd.en;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;

    // Room counts the read still in flight in the line store.
    assign pending = r_count + FIFO_CW'(i_rd.en);
    assign o_room  = (pending < FIFO_CW'(FIFO_DEPTH));

    // FIFO storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= {i_rd.last, i_rd_data};
        end
    end

    // FIFO pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PW'(1);
            end
            r_count <= r_count + FIFO_CW'(push) - FIFO_CW'(pop);
        end
    end

    assign o_px   = r_fifo[r_rd_ptr][DW-1:0];
    assign o_last = r_fifo[r_rd_ptr][DW];

endmodule

`default_nettype wire

### src/image_row_mirror.sv
// Top level of the image row mirror: configuration register, front end,
// line store and back end. Depends on irm_pkg, irm_front, irm_line_store, irm_back.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_op, i_chan0..i_chan3
//   output    out        o_valid / i_stall   o_out_chan0..o_out_chan3, o_row_end
//   config    in         psel / penable      paddr, pwdata, prdata (APB)
//
// One transaction is accepted per clock while o_stall is low; a mirrored pixel
// passes through the line store read register, then the result FIFO, on its way out.
// The rate is set by the single write and single read port of the line store.
// Reset clears the counters, bank select and FIFO; line store contents stay.
// o_stall rises when the four-entry result FIFO and the read still in flight
// together hold four pixels, which only a stalled output brings about.
`timescale 1ns / 1ps
`default_nettype none

module image_row_mirror
    import irm_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_chan0,
    input  wire logic [7:0]  i_chan1,
    input  wire logic [7:0]  i_chan2,
    input  wire logic [7:0]  i_chan3,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_chan0,
    output logic [7:0]       o_out_chan1,
    output logic [7:0]       o_out_chan2,
    output logic [7:0]       o_out_chan3,
    output logic             o_row_end
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = CHAN_W * MAX_CHANNELS;

    logic [10:0]   r_row_width;
    logic [CW-1:0] width;
    logic          room;
    t_port_px      in_px;
    t_port_px      out_px;
    logic          wr_en;
    logic [IW:0]   wr_addr;
    logic [DW-1:0] wr_data;
    t_rd_req       rd_req;
    logic [IW:0]   rd_addr;
    t_rd_req       rd;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] back_px;

    // Configuration register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= 11'd640;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_ROW_WIDTH) begin
            r_row_width <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ROW_WIDTH) ? 32'(r_row_width) : '0;

    // Effective row width, clamped to 1..MAX_WIDTH.
    always_comb begin
        if (r_row_width == '0) begin
            width = CW'(1);
        end else if (32'(r_row_width) > 32'(MAX_WIDTH)) begin
            width = CW'(MAX_WIDTH);
        end else begin
            width = CW'(r_row_width);
        end
    end

    assign in_px = {i_chan3, i_chan2, i_chan1, i_chan0};

    irm_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (width),
        .i_room    (room),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_op      (t_op'(i_op)),
        .i_px      (in_px[MAX_CHANNELS-1:0]),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_req  (rd_req),
        .o_rd_addr (rd_addr)
    );

    irm_line_store #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_req  (rd_req),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .o_rd_data (rd_data)
    );

    irm_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd),
        .i_rd_data (rd_data),
        .o_room    (room),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_px      (back_px),
        .o_last    (o_row_end)
    );

    // Unused channels read as zero.
    assign out_px      = t_port_px'(back_px);
    assign o_out_chan0 = out_px[0];
    assign o_out_chan1 = out_px[1];
    assign o_out_chan2 = out_px[2];
    assign o_out_chan3 = out_px[3];

endmodule

`default_nettype wire
